// ----- design/gffr_pkg.sv -----
`timescale 1ns / 1ps

package gffr_pkg;

  // Default grid size
  localparam int DEF_GRID_COLS = 8;
  localparam int DEF_GRID_ROWS = 15;

  // Field widths
  localparam int RECT_W = 4;
  localparam int SLOT_W = 7;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 8;

  // Request kinds
  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESP
  } state_t;

  // Commands from the sequencer to the occupancy store
  typedef struct packed {
    logic clear;
    logic set_en;
  } grid_cmd_t;

  // Commands from the sequencer to the fit unit
  typedef struct packed {
    logic run_clr;
    logic run_step;
  } fit_cmd_t;

endpackage

// ----- design/gffr_grid.sv -----
`timescale 1ns / 1ps

module gffr_grid #(
  parameter int GRID_COLS = gffr_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = gffr_pkg::DEF_GRID_ROWS,
  localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gffr_pkg::grid_cmd_t   cmd,
  input  logic [ROW_W-1:0]      set_row,
  input  logic [GRID_COLS-1:0]  set_mask,
  input  logic [ROW_W-1:0]      rd_row,
  output logic [GRID_COLS-1:0]  rd_used
);

  // One bit per cell, one word per grid row
  logic [GRID_COLS-1:0] rows_r [GRID_ROWS];

  // Clear all rows, or merge a rectangle's columns into one row
  always_ff @(posedge clk) begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      if (!rst_n || cmd.clear) begin
        rows_r[r] <= '0;
      end else if (cmd.set_en && (int'(set_row) == r)) begin
        rows_r[r] <= rows_r[r] | set_mask;
      end
    end
  end

  // Read the row under scan
  assign rd_used = rows_r[rd_row];

endmodule

// ----- design/gffr_fit.sv -----
`timescale 1ns / 1ps

module gffr_fit #(
  parameter int GRID_COLS = gffr_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = gffr_pkg::DEF_GRID_ROWS,
  localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1,
  localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gffr_pkg::fit_cmd_t          cmd,
  input  logic [GRID_COLS-1:0]        row_used,
  input  logic [ROW_W-1:0]            row_idx,
  input  logic [gffr_pkg::RECT_W-1:0] rect_w,
  input  logic [gffr_pkg::RECT_W-1:0] rect_h,
  input  logic                        zero_mode,
  output logic                        hit,
  output logic [COL_W-1:0]            hit_col,
  output logic [GRID_COLS-1:0]        hit_mask
);

  localparam int RUN_W = $clog2(GRID_ROWS + 1);

  // Free rows in each column ending at the current row
  logic [RUN_W-1:0] run_r   [GRID_COLS];
  logic [RUN_W-1:0] run_nxt [GRID_COLS];
  logic [GRID_COLS-1:0] col_ok;
  logic             row_fits;

  // Extend free runs with the row just read
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      run_nxt[c] = row_used[c] ? '0 : run_r[c] + RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < GRID_COLS; c++) begin
      if (!rst_n || cmd.run_clr) begin
        run_r[c] <= '0;
      end else if (cmd.run_step) begin
        run_r[c] <= run_nxt[c];
      end
    end
  end

  // Rectangle must end at or above the last row
  assign row_fits = (6'(row_idx) + 6'(rect_h)) <= 6'(GRID_ROWS);

  // Check every candidate column against the window of free runs, or in zero mode against the current row
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      if (zero_mode) begin
        col_ok[c] = !row_used[c] && row_fits &&
                    ((6'(c) + 6'(rect_w)) <= 6'(GRID_COLS));
      end else begin
        // Rectangle must end at or left of the last column
        col_ok[c] = (6'(c) + 6'(rect_w)) <= 6'(GRID_COLS);
        for (int k = 0; k < GRID_COLS; k++) begin
          if (6'(k) < 6'(rect_w)) begin
            if (c + k >= GRID_COLS) begin
              col_ok[c] = 1'b0;
            end else if (6'(run_nxt[(c + k) % GRID_COLS]) < 6'(rect_h)) begin
              col_ok[c] = 1'b0;
            end
          end
        end
      end
    end
  end

  // Pick the leftmost fitting column
  always_comb begin
    hit     = 1'b0;
    hit_col = '0;
    for (int c = GRID_COLS - 1; c >= 0; c--) begin
      if (col_ok[c]) begin
        hit     = 1'b1;
        hit_col = COL_W'(c);
      end
    end
  end

  // Columns covered by the rectangle at the chosen corner
  always_comb begin
    for (int k = 0; k < GRID_COLS; k++) begin
      hit_mask[k] = (6'(k) >= 6'(hit_col)) &&
                    (6'(k) < (6'(hit_col) + 6'(rect_w)));
    end
  end

endmodule

// ----- design/grid_first_fit_rect_placer.sv -----
`timescale 1ns / 1ps

// First-fit rectangle placer over a GRID_COLS by GRID_ROWS occupancy grid.
// A place beat (tuser kind = 0) scans grid rows top to bottom, one row per
// cycle, keeping a free-run count per column so that a rectangle is found
// at the row where its bottom edge lands; the leftmost column of the
// earliest top row wins. A hit then sets the covered cells one row per
// cycle, and the result is then posted from the response state once the
// output register is free. A clear beat (kind = 1) frees all cells at
// once and goes straight to the response state. The input is not ready
// while a request is in work; one result waits in the output register
// while the next request is taken. The result carries placed in tuser
// and the top-left slot row * GRID_COLS + col in tdata (0 when nothing
// is placed).
module grid_first_fit_rect_placer #(
  parameter int GRID_COLS = gffr_pkg::DEF_GRID_COLS,
  parameter int GRID_ROWS = gffr_pkg::DEF_GRID_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: rect_width [3:0], rect_height [7:4]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gffr_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind [0]
  input  logic                            in_tuser,
  // out_tdata: slot_index [6:0], zero [7]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gffr_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: placed [0]
  output logic                            out_tuser
);

  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int SFULL  = $clog2(GRID_ROWS * GRID_COLS + 1);
  localparam int SW     = (SFULL > gffr_pkg::SLOT_W) ? SFULL : gffr_pkg::SLOT_W;
  localparam int RW     = gffr_pkg::RECT_W;

  gffr_pkg::state_t state_r, state_nxt;

  logic [RW-1:0]        w_r, w_nxt;
  logic [RW-1:0]        h_r, h_nxt;
  logic                 zero_r, zero_nxt;
  logic [ROW_W-1:0]     scan_r, scan_nxt;
  logic [ROW_W-1:0]     mark_row_r, mark_row_nxt;
  logic [RW-1:0]        mark_cnt_r, mark_cnt_nxt;
  logic [GRID_COLS-1:0] mask_r, mask_nxt;
  logic                 placed_r, placed_nxt;
  logic [gffr_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_placed_r, out_placed_nxt;
  logic [gffr_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;

  gffr_pkg::grid_cmd_t  grid_cmd;
  gffr_pkg::fit_cmd_t   fit_cmd;
  logic [GRID_COLS-1:0] row_used;
  logic                 hit;
  logic [COL_W-1:0]     hit_col;
  logic [GRID_COLS-1:0] hit_mask;
  logic [ROW_W-1:0]     top_row;
  logic [SW-1:0]        slot_full;
  logic                 in_beat;

  gffr_grid #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_grid (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (grid_cmd),
    .set_row  (mark_row_r),
    .set_mask (mask_r),
    .rd_row   (scan_r),
    .rd_used  (row_used)
  );

  gffr_fit #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_fit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fit_cmd),
    .row_used  (row_used),
    .row_idx   (scan_r),
    .rect_w    (w_r),
    .rect_h    (h_r),
    .zero_mode (zero_r),
    .hit       (hit),
    .hit_col   (hit_col),
    .hit_mask  (hit_mask)
  );

  assign in_tready  = (state_r == gffr_pkg::ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_placed_r;
  assign out_tdata  = {(gffr_pkg::OUT_DATA_W - gffr_pkg::SLOT_W)'(0), out_slot_r};

  // Top row of a hit: the bottom row found, raised by the height; in zero mode the row found itself
  always_comb begin
    if (zero_r) begin
      top_row = scan_r;
    end else begin
      top_row = ROW_W'(6'(scan_r) + 6'd1 - 6'(h_r));
    end
  end

  assign slot_full = SW'(top_row) * SW'(GRID_COLS) + SW'(hit_col);

  // Sequence scan, mark and response
  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    h_nxt          = h_r;
    zero_nxt       = zero_r;
    scan_nxt       = scan_r;
    mark_row_nxt   = mark_row_r;
    mark_cnt_nxt   = mark_cnt_r;
    mask_nxt       = mask_r;
    placed_nxt     = placed_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r;
    out_placed_nxt = out_placed_r;
    out_slot_nxt   = out_slot_r;
    grid_cmd       = '0;
    fit_cmd        = '0;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      gffr_pkg::ST_IDLE: begin
        if (in_beat) begin
          placed_nxt = 1'b0;
          slot_nxt   = '0;
          if (in_tuser == gffr_pkg::KIND_CLEAR) begin
            grid_cmd.clear = 1'b1;
            state_nxt      = gffr_pkg::ST_RESP;
          end else begin
            w_nxt           = in_tdata[RW-1:0];
            h_nxt           = in_tdata[2*RW-1:RW];
            zero_nxt        = (in_tdata[RW-1:0] == '0) || (in_tdata[2*RW-1:RW] == '0);
            scan_nxt        = '0;
            fit_cmd.run_clr = 1'b1;
            state_nxt       = gffr_pkg::ST_SCAN;
          end
        end
      end

      gffr_pkg::ST_SCAN: begin
        fit_cmd.run_step = 1'b1;
        if (hit) begin
          placed_nxt   = 1'b1;
          slot_nxt     = slot_full[gffr_pkg::SLOT_W-1:0];
          mark_row_nxt = top_row;
          mark_cnt_nxt = h_r;
          mask_nxt     = hit_mask;
          state_nxt    = zero_r ? gffr_pkg::ST_RESP : gffr_pkg::ST_MARK;
        end else if (int'(scan_r) == GRID_ROWS - 1) begin
          state_nxt = gffr_pkg::ST_RESP;
        end else begin
          scan_nxt = scan_r + ROW_W'(1);
        end
      end

      gffr_pkg::ST_MARK: begin
        grid_cmd.set_en = 1'b1;
        mark_row_nxt    = mark_row_r + ROW_W'(1);
        mark_cnt_nxt    = mark_cnt_r - RW'(1);
        if (mark_cnt_r == RW'(1)) begin
          state_nxt = gffr_pkg::ST_RESP;
        end
      end

      gffr_pkg::ST_RESP: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_placed_nxt = placed_r;
          out_slot_nxt   = slot_r;
          state_nxt      = gffr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = gffr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gffr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    h_r          <= h_nxt;
    zero_r       <= zero_nxt;
    scan_r       <= scan_nxt;
    mark_row_r   <= mark_row_nxt;
    mark_cnt_r   <= mark_cnt_nxt;
    mask_r       <= mask_nxt;
    placed_r     <= placed_nxt;
    slot_r       <= slot_nxt;
    out_placed_r <= out_placed_nxt;
    out_slot_r   <= out_slot_nxt;
  end

endmodule

// ----- test/tb_grid_first_fit_rect_placer.sv -----
`timescale 1ns / 1ps

module tb_grid_first_fit_rect_placer;
  import gffr_pkg::*;

  localparam int COLS        = DEF_GRID_COLS;
  localparam int ROWS        = DEF_GRID_ROWS;
  localparam int CELLS       = COLS * ROWS;
  localparam int RAND_ITEMS  = 400;
  localparam int DRAIN_WAIT  = 64;
  localparam int CYCLE_LIMIT = 400000;

  // One place or clear request as the sender sees it
  typedef struct {
    logic            kind;
    logic [RECT_W-1:0] w;
    logic [RECT_W-1:0] h;
    bit              drain;
  } req_t;

  // One predicted answer
  typedef struct packed {
    logic              placed;
    logic [SLOT_W-1:0] slot;
  } placement_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  grid_first_fit_rect_placer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  req_t        req_q[$];
  placement_t  expected_placements[$];
  bit          grid_used [CELLS];
  int unsigned err_count;
  int unsigned cycle_cnt;
  bit          in_fire;
  int unsigned send_gap;
  int unsigned send_calm;
  int unsigned rdy_stall;
  int unsigned rdy_calm;
  logic        nxt_valid;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mirror of the occupancy grid: clear, or first-fit scan and mark
  function automatic placement_t predict_placement(req_t rq);
    placement_t res;
    int         wd;
    int         ht;
    bit         fits;
    res = '0;
    wd  = int'(rq.w);
    ht  = int'(rq.h);
    if (rq.kind == KIND_CLEAR) begin
      foreach (grid_used[i]) grid_used[i] = 1'b0;
      return res;
    end
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (!grid_used[r * COLS + c]) begin
          fits = (c + wd <= COLS) && (r + ht <= ROWS);
          for (int dr = 0; dr < ht && fits; dr++)
            for (int dc = 0; dc < wd; dc++)
              if (grid_used[(r + dr) * COLS + c + dc]) fits = 1'b0;
          if (fits) begin
            for (int dr = 0; dr < ht; dr++)
              for (int dc = 0; dc < wd; dc++)
                grid_used[(r + dr) * COLS + c + dc] = 1'b1;
            res.placed = 1'b1;
            res.slot   = SLOT_W'(r * COLS + c);
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_place(int unsigned wd, int unsigned ht, bit drain);
    req_t rq;
    rq.kind  = KIND_PLACE;
    rq.w     = RECT_W'(wd);
    rq.h     = RECT_W'(ht);
    rq.drain = drain;
    req_q.push_back(rq);
  endtask

  task automatic add_clear(bit drain);
    req_t rq;
    rq.kind  = KIND_CLEAR;
    rq.w     = RECT_W'($urandom_range(0, 15));
    rq.h     = RECT_W'($urandom_range(0, 15));
    rq.drain = drain;
    req_q.push_back(rq);
  endtask

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Drive the request stream at the falling edge
  always @(negedge clk) begin
    nxt_valid = 1'b0;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (in_tvalid && !in_fire) begin
      nxt_valid = 1'b1;
    end else begin
      in_fire = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (req_q.size() != 0) begin
        // hold off until the block has answered everything so far
        if (!(req_q[0].drain && expected_placements.size() != 0)) begin
          req_q[0].drain = 1'b0;
          nxt_valid = 1'b1;
          in_tdata <= {req_q[0].h, req_q[0].w};
          in_tuser <= req_q[0].kind;
          if (send_calm > 0) begin
            send_calm--;
          end else if ($urandom_range(0, 39) == 0) begin
            send_calm = $urandom_range(20, 60);
          end else begin
            send_gap = pick_gap();
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rdy_stall > 0) begin
      rdy_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (rdy_calm > 0) begin
        rdy_calm--;
      end else if ($urandom_range(0, 49) == 0) begin
        rdy_calm = $urandom_range(30, 100);
      end else begin
        rdy_stall = pick_gap();
      end
    end
  end

  // Check result beats, then predict for accepted request beats
  always @(posedge clk) begin
    placement_t want;
    req_t       rq;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_placements.size() == 0) begin
          note_error($sformatf("result beat with none expected: placed=%0b slot=%0d",
                               out_tuser, out_tdata[SLOT_W-1:0]));
        end else begin
          want = expected_placements.pop_front();
          if (out_tuser !== want.placed)
            note_error($sformatf("placed: expected %0b, got %0b", want.placed, out_tuser));
          if (out_tdata[SLOT_W-1:0] !== want.slot)
            note_error($sformatf("slot_index: expected %0d, got %0d",
                                 want.slot, out_tdata[SLOT_W-1:0]));
        end
      end
      if (in_tvalid && in_tready) begin
        rq = req_q.pop_front();
        expected_placements.push_back(predict_placement(rq));
        in_fire = 1'b1;
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_grid_first_fit_rect_placer: FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_PLACE;
    out_tready = 1'b0;
    err_count  = 0;
    cycle_cnt  = 0;
    in_fire    = 1'b0;
    send_gap   = 0;
    send_calm  = 0;
    rdy_stall  = 0;
    rdy_calm   = 0;

    // Directed: extremes, zero sizes, oversize, full grid, clear
    add_place(1, 1, 1'b0);
    add_place(0, 1, 1'b0);
    add_place(3, 0, 1'b0);
    add_place(8, 1, 1'b0);
    add_place(9, 1, 1'b0);
    add_place(15, 15, 1'b0);
    add_place(1, 15, 1'b0);
    add_place(1, 14, 1'b0);
    add_clear(1'b1);
    add_place(8, 15, 1'b0);
    add_place(0, 0, 1'b0);
    add_place(1, 1, 1'b0);
    add_clear(1'b0);
    add_place(7, 14, 1'b0);
    add_place(1, 15, 1'b0);
    add_place(7, 1, 1'b0);
    add_place(0, 15, 1'b0);
    add_clear(1'b0);
    add_place(4, 15, 1'b0);
    add_place(4, 15, 1'b0);
    add_place(1, 1, 1'b0);
    add_clear(1'b0);
    add_place(15, 0, 1'b0);
    add_place(1, 8, 1'b0);
    add_place(2, 16 - 1, 1'b0);

    // Random: mostly small rectangles that fill the grid, rare clears and odd sizes
    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        add_clear($urandom_range(0, 49) == 0 || i == 0);
      end else if (r < 12) begin
        add_place($urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 49) == 0 || i == 0);
      end else begin
        add_place($urandom_range(1, 4), $urandom_range(1, 5),
                  $urandom_range(0, 49) == 0 || i == 0);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every request to go out and every answer to return
    while (req_q.size() != 0 || expected_placements.size() != 0 || in_tvalid)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_count == 0 && expected_placements.size() == 0) begin
      $display("tb_grid_first_fit_rect_placer: PASS");
    end else begin
      $display("tb_grid_first_fit_rect_placer: FAIL");
    end
    $finish;
  end

endmodule
